// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the arm swing checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arm swing check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arm swing check failed: next-cycle implication");

`endif

// ===== rtl/aspg_pkg.sv =====
// ----------------------------------------------------------------------------
// aspg_pkg
// Types, constants and elaboration-time helpers of the arm swing generator.
// ----------------------------------------------------------------------------
package aspg_pkg;

    localparam int FRAME_BITS_DEF = 10;
    localparam int SINE_DEPTH_DEF = 256;

    localparam int LEN_W      = 10;   // phase length fields
    localparam int FRAC_W     = 16;   // quotient bits of the phase fraction
    localparam int P_W        = 17;   // fraction incl. the value 1.0
    localparam int ANGLE_W    = 16;   // Q3.12 angles
    localparam int AMP_W      = 13;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SINE_W     = 16;

    localparam logic [P_W-1:0]    FRAC_ONE   = 17'h10000;
    localparam logic [SINE_W-1:0] SINE_PEAK  = 16'h8000;
    localparam logic signed [15:0] INV_PI_Q16 = 16'sd20861;
    localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;

    // Divisors (2n)(2n+1) of the Taylor series terms.
    localparam logic [63:0] SER_DIV [1:9] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
    };

    typedef enum logic [1:0] {
        PH_SUPPORT = 2'd0,
        PH_SWING   = 2'd1,
        PH_DOUBLE  = 2'd2,
        PH_PERSIST = 2'd3
    } phase_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK        = 2'd0,
        CMD_START_LEFT  = 2'd1,
        CMD_START_RIGHT = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IS_LEFT_ARM         = 2'd0,
        CFG_SWING_AMPLITUDE     = 2'd1,
        CFG_SHOULDER_PITCH_BASE = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_DIV,
        SQ_LOOKUP,
        SQ_MUL_T,
        SQ_CYC,
        SQ_MUL_P,
        SQ_SUM,
        SQ_OUT
    } seq_state_t;

    typedef struct packed {
        logic              done;
        logic [FRAC_W-1:0] quotient;
    } div_status_t;

    function automatic phase_t next_phase(input phase_t ph);
        phase_t nx;
        unique case (ph)
            PH_SUPPORT: nx = PH_DOUBLE;
            PH_SWING:   nx = PH_PERSIST;
            PH_DOUBLE:  nx = PH_SWING;
            PH_PERSIST: nx = PH_SUPPORT;
            default:    nx = PH_SUPPORT;
        endcase
        return nx;
    endfunction

    // Quarter-wave sine entry in Q0.15 from an angle in Q30 radians.
    // Evaluated at elaboration only.
    function automatic logic [SINE_W-1:0] sine_series(input logic [63:0] x);
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        rounded;
        term = x;
        sum  = signed'(x);
        for (int n = 1; n <= 9; n++) begin
            term = (term * x) >> 30;
            term = ((term * x) >> 30) / SER_DIV[n];
            if (n[0])
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            sum = 64'sd0;
        rounded = (unsigned'(sum) + 64'd16384) >> 15;
        return rounded[SINE_W-1:0];
    endfunction

endpackage

// ===== rtl/aspg_frac_div.sv =====
// ----------------------------------------------------------------------------
// aspg_frac_div
// Restoring divider, one quotient bit a cycle: floor(count * 2^16 / len),
// for count below len.
// ----------------------------------------------------------------------------
module aspg_frac_div
    import aspg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [LEN_W-1:0]  count,
    input  logic [LEN_W-1:0]  len,
    output div_status_t       status
);

    localparam int STEP_W = $clog2(FRAC_W);

    logic [LEN_W-1:0]  rem_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [FRAC_W-1:0] quo_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [LEN_W:0]    rem_dbl;
    logic [LEN_W:0]    rem_sub;
    logic              ge;
    logic [LEN_W-1:0]  rem_new;

    always_comb
    begin
        rem_dbl = {rem_reg, 1'b0};
        rem_sub = rem_dbl - {1'b0, len_reg};
        ge      = (rem_dbl >= {1'b0, len_reg});
        rem_new = ge ? rem_sub[LEN_W-1:0] : rem_dbl[LEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(FRAC_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= count;
            len_reg <= len;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_new;
            quo_reg <= {quo_reg[FRAC_W-2:0], ge};
        end
    end

    assign status.done     = done_reg;
    assign status.quotient = quo_reg;

endmodule

// ===== rtl/aspg_sine_rom.sv =====
// ----------------------------------------------------------------------------
// aspg_sine_rom
// Quarter-wave sine table in Q0.15 with a registered read; the entry past
// the end holds the peak value.
// ----------------------------------------------------------------------------
module aspg_sine_rom
    import aspg_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH) + 1
)
(
    input  logic              clk,
    input  logic [IDX_W-1:0]  index,
    output logic [SINE_W-1:0] data
);

    logic [SINE_W-1:0] rom [0:SINE_TABLE_DEPTH];
    logic [SINE_W-1:0] data_reg;

    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++)
    begin : g_entry
        localparam logic [63:0] XV =
            (HALF_PI_Q30 * 64'(g)) / 64'(SINE_TABLE_DEPTH);
        localparam logic [SINE_W-1:0] ENTRY = sine_series(XV);
        assign rom[g] = ENTRY;
    end

    assign rom[SINE_TABLE_DEPTH] = SINE_PEAK;

    always_ff @(posedge clk)
    begin
        data_reg <= rom[index];
    end

    assign data = data_reg;

endmodule

// ===== rtl/arm_swing_phase_generator_top.sv =====
// ----------------------------------------------------------------------------
// arm_swing_phase_generator_top
// Shoulder pitch of one walking arm from a four-phase gait machine.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one command beat. A tick beat
//   yields one output beat (shoulder_pitch, phase); start-left, start-right
//   and the unused command code yield none.
//   Configuration channel (cfg_valid/cfg_ready) is always ready; write it
//   only while the block is idle.
// Processing:
//   Start commands update the gait state when accepted. A tick whose
//   fraction needs the divider runs the 16-step restoring divider, then
//   a table read and two passes through the shared multiplier; a tick
//   at a full fraction skips the divider. One item is in flight at a
//   time; in_ready is low while it works.
// Reset:
//   Phase supporting, frame count zero, first step set; left arm,
//   amplitude zero, base zero. No reset sweep is needed.
// Stall:
//   A finished result waits in the output register. The next beat is
//   accepted meanwhile; its result waits until the register is taken.
// ----------------------------------------------------------------------------
module arm_swing_phase_generator_top
    import aspg_pkg::*;
#(
    parameter int FRAME_BITS       = FRAME_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [CMD_W-1:0]          command,
    input  logic [LEN_W-1:0]          single_support_frames,
    input  logic [LEN_W-1:0]          double_support_frames,
    input  logic                      step_is_end,

    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [ANGLE_W-1:0] shoulder_pitch,
    output logic [1:0]                phase,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    localparam int LOG2D     = $clog2(SINE_TABLE_DEPTH);
    localparam int IDX_W     = LOG2D + 1;
    localparam int POS_SHIFT = 14 - LOG2D;    // p * 4 * depth / 2^16
    localparam int CMP_W     = (FRAME_BITS > LEN_W) ? FRAME_BITS : LEN_W;
    localparam int END_W     = AMP_W + 1;     // signed endpoints
    localparam int DIFF_W    = END_W + 1;
    localparam int MA_W      = 18;            // shared multiplier operands
    localparam int MB_W      = 16;
    localparam int MP_W      = MA_W + MB_W;
    localparam logic [FRAME_BITS-1:0] COUNT_MAX = '1;

    // ---------------------------------------------------------------- state
    seq_state_t state_reg, state_next;

    logic                      is_left_arm_reg;
    logic [AMP_W-1:0]          swing_amplitude_reg;
    logic signed [ANGLE_W-1:0] base_reg;

    phase_t                    phase_reg;
    logic [FRAME_BITS-1:0]     frame_count_reg;
    logic                      first_step_reg;
    logic                      last_was_end_reg;

    // Per-item working registers.
    logic [LEN_W-1:0]          ssf_reg;
    logic [LEN_W-1:0]          dsf_reg;
    logic                      is_end_reg;
    logic signed [END_W-1:0]   start_reg;
    logic signed [END_W-1:0]   end_reg;
    logic [P_W-1:0]            p_reg;
    logic                      sine_neg_reg;
    logic                      sine_zero_reg;
    logic [P_W-1:0]            c_reg;
    logic signed [MP_W-1:0]    mul_reg;
    logic signed [ANGLE_W-1:0] result_reg;

    logic                      out_valid_reg;
    logic signed [ANGLE_W-1:0] pitch_out_reg;
    phase_t                    phase_out_reg;

    // ------------------------------------------------------------ handshake
    logic in_fire;
    logic out_free;
    logic is_tick;

    assign in_ready  = (state_reg == SQ_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign is_tick   = (command == CMD_TICK);
    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------- tick set-up
    logic                    swing_fwd;
    logic signed [END_W-1:0] amp_s;
    logic signed [END_W-1:0] start_pre;
    logic signed [END_W-1:0] start_sel;
    logic signed [END_W-1:0] end_sel;
    logic                    use_len;
    logic [LEN_W-1:0]        len_sel;
    logic                    frac_full;
    logic                    div_start;
    div_status_t             div_status;

    always_comb
    begin
        swing_fwd = (phase_reg == PH_SWING) || (phase_reg == PH_PERSIST);
        amp_s     = signed'({1'b0, swing_amplitude_reg});
        start_pre = swing_fwd ? -amp_s : amp_s;
        // End steps: drop the swing, or fold it toward / away from zero.
        if (!step_is_end)
        begin
            start_sel = start_pre;
            end_sel   = -start_pre;
        end
        else if (last_was_end_reg)
        begin
            start_sel = '0;
            end_sel   = '0;
        end
        else if (first_step_reg)
        begin
            start_sel = '0;
            end_sel   = start_pre;
        end
        else
        begin
            start_sel = -start_pre;
            end_sel   = '0;
        end

        use_len   = step_is_end || (phase_reg == PH_SUPPORT) || (phase_reg == PH_SWING);
        len_sel   = step_is_end ? double_support_frames : single_support_frames;
        frac_full = !use_len || (len_sel == '0)
                    || (CMP_W'(frame_count_reg) >= CMP_W'(len_sel));
        div_start = in_fire && is_tick && !frac_full;
    end

    aspg_frac_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .count  (LEN_W'(frame_count_reg)),
        .len    (len_sel),
        .status (div_status)
    );

    // ----------------------------------------------------------- sine lookup
    logic [P_W-1:0]    pos_full;
    logic [2:0]        quad;
    logic [LOG2D-1:0]  pos_k;
    logic [IDX_W-1:0]  rom_index;
    logic [SINE_W-1:0] rom_data;

    always_comb
    begin
        pos_full = p_reg >> POS_SHIFT;
        quad     = pos_full[LOG2D+2:LOG2D];
        pos_k    = pos_full[LOG2D-1:0];
        // Mirror the table in the second and fourth quadrants.
        if (quad[0])
            rom_index = IDX_W'(SINE_TABLE_DEPTH) - {1'b0, pos_k};
        else
            rom_index = {1'b0, pos_k};
    end

    aspg_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .clk   (clk),
        .index (rom_index),
        .data  (rom_data)
    );

    // ------------------------------------------------------ shared multiply
    logic [SINE_W-1:0]       sine_mag;
    logic signed [DIFF_W-1:0] diff;
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [MP_W-1:0]  mul_p;

    always_comb
    begin
        sine_mag = sine_zero_reg ? '0 : rom_data;
        diff     = DIFF_W'(end_reg) - DIFF_W'(start_reg);
        if (state_reg == SQ_MUL_T)
        begin
            mul_a = signed'(MA_W'(sine_mag));
            mul_b = INV_PI_Q16;
        end
        else
        begin
            mul_a = signed'(MA_W'(c_reg));
            mul_b = MB_W'(diff);
        end
        mul_p = mul_a * mul_b;
    end

    // ------------------------------------------------------------ cycloid
    logic signed [MP_W-1:0] t_sum;
    logic [14:0]            t_val;
    logic signed [P_W+1:0]  c_wide;
    logic [P_W-1:0]         c_clamp;

    always_comb
    begin
        t_sum  = mul_reg + MP_W'(16384);
        t_val  = t_sum[29:15];
        if (sine_neg_reg)
            c_wide = signed'((P_W+2)'(p_reg)) + signed'((P_W+2)'(t_val));
        else
            c_wide = signed'((P_W+2)'(p_reg)) - signed'((P_W+2)'(t_val));
        if (c_wide < 0)
            c_clamp = '0;
        else if (c_wide > signed'((P_W+2)'(FRAC_ONE)))
            c_clamp = FRAC_ONE;
        else
            c_clamp = c_wide[P_W-1:0];
    end

    // ----------------------------------------------------- sum and saturate
    logic                      prod_neg;
    logic [MP_W-1:0]           prod_mag;
    logic [MP_W-1:0]           r_sum;
    logic signed [ANGLE_W-1:0] r_val;
    logic signed [ANGLE_W-1:0] add_val;
    logic signed [ANGLE_W+1:0] total;
    logic signed [ANGLE_W-1:0] total_sat;

    always_comb
    begin
        prod_neg = mul_reg < 0;
        prod_mag = prod_neg ? unsigned'(-mul_reg) : unsigned'(mul_reg);
        r_sum    = prod_mag + MP_W'(32768);
        r_val    = signed'(ANGLE_W'(r_sum[29:16]));
        add_val  = ANGLE_W'(start_reg) + (prod_neg ? -r_val : r_val);
        total    = (ANGLE_W+2)'(base_reg) + (ANGLE_W+2)'(add_val);
        if (total > (ANGLE_W+2)'(32767))
            total_sat = 16'sh7FFF;
        else if (total < -(ANGLE_W+2)'(32768))
            total_sat = 16'sh8000;
        else
            total_sat = total[ANGLE_W-1:0];
    end

    // --------------------------------------------------------- phase update
    // Advance the count, then up to two phase switches.
    logic [FRAME_BITS-1:0] fc_inc;
    logic [LEN_W-1:0]      len1;
    logic                  sw1;
    phase_t                ph1;
    logic [LEN_W-1:0]      len2;
    logic                  sw2;
    phase_t                ph_final;

    always_comb
    begin
        fc_inc   = (frame_count_reg == COUNT_MAX) ? frame_count_reg : frame_count_reg + 1'b1;
        len1     = (phase_reg == PH_SUPPORT || phase_reg == PH_SWING) ? ssf_reg : dsf_reg;
        sw1      = CMP_W'(fc_inc) >= CMP_W'(len1);
        ph1      = sw1 ? next_phase(phase_reg) : phase_reg;
        len2     = (ph1 == PH_SUPPORT || ph1 == PH_SWING) ? ssf_reg : dsf_reg;
        // After a switch the count is zero, so a second one needs a zero length.
        sw2      = sw1 && (len2 == '0);
        ph_final = sw2 ? next_phase(ph1) : ph1;
    end

    // ------------------------------------------------------------ sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SQ_IDLE:
            begin
                if (in_fire && is_tick)
                    state_next = frac_full ? SQ_LOOKUP : SQ_DIV;
            end
            SQ_DIV:
            begin
                if (div_status.done)
                    state_next = SQ_LOOKUP;
            end
            SQ_LOOKUP: state_next = SQ_MUL_T;
            SQ_MUL_T:  state_next = SQ_CYC;
            SQ_CYC:    state_next = SQ_MUL_P;
            SQ_MUL_P:  state_next = SQ_SUM;
            SQ_SUM:    state_next = SQ_OUT;
            SQ_OUT:
            begin
                if (out_free)
                    state_next = SQ_IDLE;
            end
            default:   state_next = SQ_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= SQ_IDLE;
        else
            state_reg <= state_next;
    end

    // --------------------------------------------------- configuration regs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_left_arm_reg     <= 1'b1;
            swing_amplitude_reg <= '0;
            base_reg            <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_IS_LEFT_ARM:         is_left_arm_reg     <= cfg_data[0];
                CFG_SWING_AMPLITUDE:     swing_amplitude_reg <= cfg_data[AMP_W-1:0];
                CFG_SHOULDER_PITCH_BASE: base_reg            <= signed'(cfg_data);
                default:                 ;
            endcase
        end
    end

    // ------------------------------------------------------------ gait state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SUPPORT;
            frame_count_reg  <= '0;
            first_step_reg   <= 1'b1;
            last_was_end_reg <= 1'b0;
        end
        else if (in_fire && (command == CMD_START_LEFT || command == CMD_START_RIGHT))
        begin
            // Left start drops the left arm into double support first.
            if ((command == CMD_START_LEFT) == is_left_arm_reg)
                phase_reg <= PH_DOUBLE;
            else
                phase_reg <= PH_PERSIST;
            frame_count_reg  <= '0;
            first_step_reg   <= 1'b1;
            last_was_end_reg <= 1'b0;
        end
        else if (state_reg == SQ_SUM)
        begin
            phase_reg <= ph_final;
            if (sw1)
            begin
                frame_count_reg  <= '0;
                first_step_reg   <= 1'b0;
                last_was_end_reg <= is_end_reg;
            end
            else
            begin
                frame_count_reg <= fc_inc;
            end
        end
    end

    // ------------------------------------------------------------- datapath
    always_ff @(posedge clk)
    begin
        if (in_fire && is_tick)
        begin
            ssf_reg    <= single_support_frames;
            dsf_reg    <= double_support_frames;
            is_end_reg <= step_is_end;
            start_reg  <= start_sel;
            end_reg    <= end_sel;
            if (frac_full)
                p_reg <= FRAC_ONE;
        end
        if (state_reg == SQ_DIV && div_status.done)
            p_reg <= {1'b0, div_status.quotient};
        if (state_reg == SQ_LOOKUP)
        begin
            sine_neg_reg  <= quad[1];
            sine_zero_reg <= quad[2];
        end
        if (state_reg == SQ_MUL_T || state_reg == SQ_MUL_P)
            mul_reg <= mul_p;
        if (state_reg == SQ_CYC)
            c_reg <= c_clamp;
        if (state_reg == SQ_SUM)
            result_reg <= total_sat;
    end

    // ------------------------------------------------------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == SQ_OUT && out_free)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == SQ_OUT && out_free)
        begin
            pitch_out_reg <= result_reg;
            phase_out_reg <= phase_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign shoulder_pitch = pitch_out_reg;
    assign phase          = phase_out_reg;

endmodule

// ===== rtl/aspg_checker.sv =====
// ----------------------------------------------------------------------------
// aspg_checker
// Port-level checks of the arm swing generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aspg_checker
    import aspg_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic [CMD_W-1:0]          command,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [ANGLE_W-1:0] shoulder_pitch,
    input logic [1:0]                phase
);

    // A stalled result holds its beat.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(shoulder_pitch) && $stable(phase))

    // A tick occupies the block: no beat is taken in the next cycle.
    `ASSERT_NEXT(a_tick_busy, clk, rst_n, in_valid && in_ready && command == CMD_TICK, !in_ready)

    // Start commands and the unused code produce no result.
    `ASSERT_NEXT(a_no_result, clk, rst_n, in_valid && in_ready && command != CMD_TICK, !$rose(out_valid))

    // A result appears only at the end of a busy stretch.
    `ASSERT_IMPLIES(a_result_after_work, clk, rst_n, $rose(out_valid), !$past(in_ready))

endmodule

bind arm_swing_phase_generator_top aspg_checker u_aspg_checker (.*);
